// ===== hw/rtl/pgpb_pkg.sv =====
// Shared types and constants for the palettized glyph pixel blender.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pgpb_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PIX_W         = 8;
  localparam int COORD_W       = 13;
  localparam int DIM_W         = 12;
  localparam int REG_IDX_W     = 3;
  localparam int REG_DATA_W    = 12;

  typedef logic [PIX_W-1:0]          pixel_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]          dim_t;

  // Item opcodes
  localparam logic OP_BLEND     = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  // Blend modes; codes six and seven write nothing
  localparam logic [2:0] MODE_PLAIN    = 3'd0;
  localparam logic [2:0] MODE_GLOW     = 3'd1;
  localparam logic [2:0] MODE_DARKEN   = 3'd2;
  localparam logic [2:0] MODE_BANK     = 3'd3;
  localparam logic [2:0] MODE_BRIGHTEN = 3'd4;
  localparam logic [2:0] MODE_SOLID    = 3'd5;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_BANK    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SOLID_COLOR   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DARK_AMOUNT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

  localparam dim_t WIDTH_RESET  = 12'd640;
  localparam dim_t HEIGHT_RESET = 12'd480;

  // Shade band: low five bits are the shade, top three the band
  localparam logic [4:0] SHADE_MAX = 5'd31;

  typedef struct packed {
    logic [2:0]        blend_mode;
    logic signed [7:0] brightness;
    logic [2:0]        color_bank;
    pixel_t            solid_color;
    logic [7:0]        dark_amount;
    dim_t              screen_width;
    dim_t              screen_height;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pgpb_if.sv =====
// Channel interfaces of the glyph pixel blender: input items, result items
// and configuration writes. Depends on pgpb_pkg.
`default_nettype none

interface pgpb_in_if import pgpb_pkg::*;;
  logic   valid;
  logic   ready;
  logic   op;
  pixel_t glyph_value;
  pixel_t dest_value;
  coord_t pos_x;
  coord_t pos_y;
  pixel_t pal_index;
  pixel_t pal_value;

  modport source (output valid, op, glyph_value, dest_value, pos_x, pos_y,
                  pal_index, pal_value, input ready);
  modport sink   (input valid, op, glyph_value, dest_value, pos_x, pos_y,
                  pal_index, pal_value, output ready);
endinterface

interface pgpb_out_if import pgpb_pkg::*;;
  logic   valid;
  logic   ready;
  logic   write_enable;
  pixel_t pixel_value;

  modport source (output valid, write_enable, pixel_value, input ready);
  modport sink   (input valid, write_enable, pixel_value, output ready);
endinterface

interface pgpb_cfg_if import pgpb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [REG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pgpb_palette.sv =====
// Palette translation memory: 256 x 8 synchronous RAM, one read and one
// write port, with per-entry valid bits so unwritten entries read as identity.
// Depends on pgpb_pkg.
`default_nettype none

module pgpb_palette import pgpb_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          rd_en,
  input  wire  pixel_t rd_addr,
  input  wire          wr_en,
  input  wire  pixel_t wr_addr,
  input  wire  pixel_t wr_data,
  output pixel_t       rd_data
);

  pixel_t                   mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written;
  pixel_t                   rd_q;
  pixel_t                   rd_addr_q;
  logic                     rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_addr];
      end
    end
  end

  // Entry never written: identity
  assign rd_data = rd_hit ? rd_q : rd_addr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pgpb_blend.sv =====
// Blend datapath: clip test and the six mode rules for one glyph pixel.
// Purely combinational; depends on pgpb_pkg.
`default_nettype none

module pgpb_blend import pgpb_pkg::*; (
  input  wire cfg_regs_t cfg,
  input  wire            op,
  input  wire pixel_t    glyph_value,
  input  wire pixel_t    dest_value,
  input  wire coord_t    pos_x,
  input  wire coord_t    pos_y,
  input  wire pixel_t    pal_data,
  output logic           write_enable,
  output pixel_t         pixel_value
);

  logic              in_window;
  logic              bright_pos;
  logic signed [8:0] glow_s;
  logic              glow_pos;
  logic [7:0]        glow_sum;
  logic [4:0]        glow_shade;
  logic [4:0]        dark_s;
  logic [4:0]        dark_shade;
  pixel_t            shifted;
  logic              off_band;
  pixel_t            bank_pix;
  pixel_t            bright_pix;

  always_comb begin
    in_window = (glyph_value != '0)
          && !pos_x[COORD_W-1] && (pos_x != '0) && (pos_x[DIM_W-1:0] < cfg.screen_width)
          && !pos_y[COORD_W-1] && (pos_y != '0) && (pos_y[DIM_W-1:0] < cfg.screen_height);

    bright_pos = !cfg.brightness[7] && (cfg.brightness != '0);

    // Glow: saturating add on the destination shade
    glow_s     = $signed({4'b0000, pal_data[4:0]}) + $signed({cfg.brightness[7],
                                                               cfg.brightness});
    glow_pos   = !glow_s[8] && (glow_s != '0);
    glow_sum   = {3'b000, dest_value[4:0]} + glow_s[7:0];
    glow_shade = (glow_sum > {3'b000, SHADE_MAX}) ? SHADE_MAX : glow_sum[4:0];

    // Darken: floored subtracts on both shades
    dark_s     = ({3'b000, pal_data[4:0]} > cfg.dark_amount)
               ? (pal_data[4:0] - cfg.dark_amount[4:0]) : 5'd0;
    dark_shade = (dest_value[4:0] > dark_s) ? (dest_value[4:0] - dark_s) : 5'd0;

    // Bank and brighten act on the raw glyph value
    shifted  = glyph_value + pixel_t'(cfg.brightness);
    off_band = (shifted[7:5] != glyph_value[7:5]);
    bank_pix = {cfg.color_bank, off_band ? (bright_pos ? SHADE_MAX : 5'd0) : shifted[4:0]};
    bright_pix = off_band ? {glyph_value[7:5], bright_pos ? SHADE_MAX : 5'd0} : shifted;

    write_enable = 1'b0;
    pixel_value  = dest_value;
    if (op == OP_BLEND && in_window) begin
      case (cfg.blend_mode)
        MODE_PLAIN: begin
          write_enable = 1'b1;
          pixel_value  = pal_data;
        end
        MODE_GLOW: begin
          if (glow_pos) begin
            write_enable = 1'b1;
            pixel_value  = {dest_value[7:5], glow_shade};
          end
        end
        MODE_DARKEN: begin
          if (dark_s != '0) begin
            write_enable = 1'b1;
            pixel_value  = {dest_value[7:5], dark_shade};
          end
        end
        MODE_BANK: begin
          write_enable = 1'b1;
          pixel_value  = bank_pix;
        end
        MODE_BRIGHTEN: begin
          write_enable = 1'b1;
          pixel_value  = bright_pix;
        end
        MODE_SOLID: begin
          write_enable = 1'b1;
          pixel_value  = cfg.solid_color;
        end
        default: begin
          write_enable = 1'b0;
          pixel_value  = dest_value;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/palette_glyph_pixel_blender.sv =====
// Palettized glyph pixel blender: top level with the two-stage item pipeline
// and configuration registers. Depends on pgpb_pkg, pgpb_if, pgpb_palette
// and pgpb_blend.
//
// Usage:
//  - pix_in carries one item per handshake: either a blend request (glyph
//    pixel, destination pixel, signed screen position) or a palette entry
//    write. Every item, palette writes included, yields exactly one result.
//  - pix_out returns write_enable and the new pixel; when write_enable is
//    low the pixel is the untouched destination value.
//  - cfg writes one register per handshake (index 0..6); it is always ready.
//    Write it only while no item is in flight.
// Timing:
//  - One item per clock while pix_out is not stalled. Stage 1 reads the palette
//    RAM (synchronous read), stage 2 is the result register, so a result is
//    offered once its item has passed stage 1 and been loaded into the
//    result register.
//  - A palette write lands in the RAM at its accept edge, so the very next
//    item already sees the new entry.
// Reset: clears the pipeline, restores register defaults (640 x 480 clip,
//  plain mode) and marks every palette entry as identity at once.
// Stall: a result held on pix_out does not block stage 1 from filling;
//  pix_in.ready drops only in reset or when both stages are full and stalled.
`default_nettype none

module palette_glyph_pixel_blender import pgpb_pkg::*; (
  input wire             clk,
  input wire             rst,
  pgpb_in_if.sink        pix_in,
  pgpb_out_if.source     pix_out,
  pgpb_cfg_if.sink       cfg
);

  cfg_regs_t regs;

  logic   in_acc;
  logic   s1_adv;
  logic   s1_valid;
  logic   s1_op;
  pixel_t s1_glyph;
  pixel_t s1_dest;
  coord_t s1_x;
  coord_t s1_y;
  pixel_t pal_data;
  logic   blend_we;
  pixel_t blend_pix;
  logic   out_valid;
  logic   out_we;
  pixel_t out_pix;

  // Configuration registers: always accept, drop unknown indexes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.blend_mode    <= MODE_PLAIN;
      regs.brightness    <= '0;
      regs.color_bank    <= '0;
      regs.solid_color   <= '0;
      regs.dark_amount   <= '0;
      regs.screen_width  <= WIDTH_RESET;
      regs.screen_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLEND_MODE:    regs.blend_mode    <= cfg.data[2:0];
        REG_BRIGHTNESS:    regs.brightness    <= $signed(cfg.data[7:0]);
        REG_COLOR_BANK:    regs.color_bank    <= cfg.data[2:0];
        REG_SOLID_COLOR:   regs.solid_color   <= cfg.data[7:0];
        REG_DARK_AMOUNT:   regs.dark_amount   <= cfg.data[7:0];
        REG_SCREEN_WIDTH:  regs.screen_width  <= cfg.data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: regs.screen_height <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1 advances whenever the result register is free or being drained
  assign s1_adv       = !out_valid || pix_out.ready;
  assign pix_in.ready = !rst && (!s1_valid || s1_adv);
  assign in_acc       = pix_in.valid && pix_in.ready;

  // Palette RAM: read the glyph's entry and store a palette write, both at
  // the accept edge; read data holds while stage 1 holds.
  pgpb_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (pix_in.glyph_value),
    .wr_en   (in_acc && (pix_in.op == OP_PAL_WRITE)),
    .wr_addr (pix_in.pal_index),
    .wr_data (pix_in.pal_value),
    .rd_data (pal_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op    <= pix_in.op;
      s1_glyph <= pix_in.glyph_value;
      s1_dest  <= pix_in.dest_value;
      s1_x     <= pix_in.pos_x;
      s1_y     <= pix_in.pos_y;
    end
  end

  pgpb_blend u_blend (
    .cfg          (regs),
    .op           (s1_op),
    .glyph_value  (s1_glyph),
    .dest_value   (s1_dest),
    .pos_x        (s1_x),
    .pos_y        (s1_y),
    .pal_data     (pal_data),
    .write_enable (blend_we),
    .pixel_value  (blend_pix)
  );

  // Result register: load from stage 1, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_we  <= blend_we;
      out_pix <= blend_pix;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.write_enable = out_we;
  assign pix_out.pixel_value  = out_pix;

endmodule

`default_nettype wire

// ===== hw/rtl/pgpb_checker.sv =====
// Port-level checks for the glyph pixel blender, bound to the top level.
// Depends on pgpb_pkg and palette_glyph_pixel_blender.
`default_nettype none

module pgpb_checker import pgpb_pkg::*; (
  input wire         clk,
  input wire         rst,
  input wire         in_valid,
  input wire         in_ready,
  input wire         out_valid,
  input wire         out_ready,
  input wire         out_we,
  input wire pixel_t out_pix
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_we) && $stable(out_pix))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pipeline not empty after reset");

  // An accepted item is followed by a result offered on pix_out
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item produced no result");

endmodule

bind palette_glyph_pixel_blender pgpb_checker u_pgpb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_we    (pix_out.write_enable),
  .out_pix   (pix_out.pixel_value)
);

`default_nettype wire
